// File: src/asp_pkg.sv
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types, constants and tables of the almanac satellite position core.
// ----------------------------------------------------------------------------
package asp_pkg;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 65;
  localparam int MUL_B_W = 40;
  localparam int MUL_P_W = 105;
  localparam int MUL_DIG = 4;

  // cordic datapath widths
  localparam int COR_XY_W = 36;
  localparam int COR_Z_W  = 34;
  localparam logic signed [COR_XY_W-1:0] COR_KINV = 36'sd652032874;

  // divider: constant dividend is round(sqrt(mu)/pi * 2^40) * 2^44
  localparam int DIV_N_W = 108;
  localparam int DIV_D_W = 72;
  localparam logic [DIV_N_W-1:0] DIV_NUM = {64'd6987452575800000000, 44'd0};

  // integer square root width
  localparam int SQ_W = 43;

  localparam logic signed [MUL_B_W-1:0] INV_PI_Q32   = 40'sd1367130551;
  localparam logic signed [MUL_A_W-1:0] NODE_TK_NEG  = 65'sd52273558800;
  localparam logic signed [MUL_A_W-1:0] NODE_AL_NEG  = 65'sd836283265931;
  localparam logic signed [25:0]        HALF_WEEK16  = 26'sd4838400;
  localparam logic signed [25:0]        WEEK16       = 26'sd9676800;

  // register map
  localparam logic REG_PERIGEE_IDX = 1'b0;
  localparam logic [31:0] PERIGEE_RST = 32'd356027127;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  // micro-sequence of the position computation
  typedef enum logic [4:0] {
    ST_SS, ST_S3, ST_DIV, ST_MK, ST_KCHK, ST_KCOR, ST_KM1, ST_KM2,
    ST_ECOR, ST_EE, ST_SQRT, ST_SQS, ST_ATAN, ST_ECOS, ST_R16, ST_UCOR,
    ST_XK, ST_YK, ST_N1, ST_N2, ST_OCOR, ST_ICOR, ST_YCI,
    ST_P1, ST_P2, ST_P3, ST_P4, ST_P5
  } step_t;

  function automatic logic [29:0] atan_lut(input logic [5:0] i);
    logic [29:0] v;
    case (i)
      6'd0:  v = 30'h20000000;
      6'd1:  v = 30'h12E4051E;
      6'd2:  v = 30'h09FB385B;
      6'd3:  v = 30'h051111D4;
      6'd4:  v = 30'h028B0D43;
      6'd5:  v = 30'h0145D7E1;
      6'd6:  v = 30'h00A2F61E;
      6'd7:  v = 30'h00517C55;
      6'd8:  v = 30'h0028BE53;
      6'd9:  v = 30'h00145F2F;
      6'd10: v = 30'h000A2F98;
      6'd11: v = 30'h000517CC;
      6'd12: v = 30'h00028BE6;
      6'd13: v = 30'h000145F3;
      6'd14: v = 30'h0000A2FA;
      6'd15: v = 30'h0000517D;
      6'd16: v = 30'h000028BE;
      6'd17: v = 30'h0000145F;
      6'd18: v = 30'h00000A30;
      6'd19: v = 30'h00000518;
      6'd20: v = 30'h0000028C;
      6'd21: v = 30'h00000146;
      6'd22: v = 30'h000000A3;
      6'd23: v = 30'h00000051;
      6'd24: v = 30'h00000029;
      6'd25: v = 30'h00000014;
      6'd26: v = 30'h0000000A;
      6'd27: v = 30'h00000005;
      6'd28: v = 30'h00000003;
      6'd29: v = 30'h00000001;
      6'd30: v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: src/asp_if.sv
// ----------------------------------------------------------------------------
// asp_in_if / asp_out_if
// Valid/ready channels carrying almanac records in and positions out.
// ----------------------------------------------------------------------------
interface asp_in_if;
  logic               valid;
  logic               ready;
  logic        [23:0] ref_time;
  logic        [19:0] alm_time;
  logic signed [31:0] mean_anom0;
  logic        [23:0] sqrt_axis;
  logic        [20:0] eccentricity;
  logic signed [31:0] inclination;
  logic signed [31:0] node_long0;

  modport source (output valid, ref_time, alm_time, mean_anom0, sqrt_axis, eccentricity,
                  inclination, node_long0, input ready);
  modport sink   (input valid, ref_time, alm_time, mean_anom0, sqrt_axis, eccentricity,
                  inclination, node_long0, output ready);
endinterface

interface asp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               converged;

  modport source (output valid, pos_x, pos_y, pos_z, converged, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, converged, output ready);
endinterface

// File: src/asp_mul.sv
// ----------------------------------------------------------------------------
// asp_mul
// Shared signed multiplier, four multiplier bits per cycle.
// ----------------------------------------------------------------------------
module asp_mul
  import asp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic                      done_o,
  output logic signed [MUL_P_W-1:0] p_o
);

  localparam int NDIG = MUL_B_W / MUL_DIG;
  localparam int CW   = $clog2(NDIG);

  logic                      busy_r;
  logic                      done_r;
  logic [CW-1:0]             cnt_r;
  logic signed [MUL_P_W-1:0] acc_r;
  logic signed [MUL_P_W-1:0] ash_r;
  logic        [MUL_B_W-1:0] bmag_r;
  logic                      neg_r;
  logic signed [MUL_P_W-1:0] acc_nxt;
  logic signed [MUL_P_W-1:0] p_r;

  assign acc_nxt = acc_r + ash_r * $signed({1'b0, bmag_r[MUL_DIG-1:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NDIG - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      acc_r  <= '0;
      ash_r  <= MUL_P_W'(a_i);
      bmag_r <= b_i[MUL_B_W-1] ? MUL_B_W'(-b_i) : MUL_B_W'(b_i);
      neg_r  <= b_i[MUL_B_W-1];
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      ash_r  <= ash_r <<< MUL_DIG;
      bmag_r <= bmag_r >> MUL_DIG;
      if (cnt_r == CW'(NDIG - 1)) begin
        p_r <= neg_r ? -acc_nxt : acc_nxt;
      end
    end
  end

  assign done_o = done_r;
  assign p_o    = p_r;

endmodule

// File: src/asp_cordic.sv
// ----------------------------------------------------------------------------
// asp_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation and vectoring mode.
// ----------------------------------------------------------------------------
module asp_cordic
  import asp_pkg::*;
#(
  parameter int STEPS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic                       vec_i,
  input  logic [31:0]                ang_i,
  input  logic signed [COR_XY_W-1:0] x_i,
  input  logic signed [COR_XY_W-1:0] y_i,
  output logic                       done_o,
  output logic signed [COR_XY_W-1:0] cos_o,
  output logic signed [COR_XY_W-1:0] sin_o,
  output logic [31:0]                ang_o
);

  localparam int CW = $clog2(STEPS);

  logic                       busy_r;
  logic                       done_r;
  logic [CW-1:0]              cnt_r;
  logic signed [COR_XY_W-1:0] x_r, y_r;
  logic signed [COR_Z_W-1:0]  z_r;
  logic [1:0]                 q_r;
  logic                       vec_r;
  logic                       base_r;
  logic signed [COR_XY_W-1:0] cos_r, sin_r;
  logic [31:0]                ang_r;

  logic [31:0]                t_rot;
  logic signed [COR_XY_W-1:0] dx, dy, x_nxt, y_nxt;
  logic signed [COR_Z_W-1:0]  at, z_nxt;
  logic                       sigma;
  logic                       last;

  assign t_rot = ang_i + 32'h2000_0000;
  assign dx    = y_r >>> cnt_r;
  assign dy    = x_r >>> cnt_r;
  assign at    = $signed({4'b0, atan_lut(6'(cnt_r))});
  assign sigma = vec_r ? y_r[COR_XY_W-1] : !z_r[COR_Z_W-1];
  assign last  = (cnt_r == CW'(STEPS - 1));

  always_comb begin
    if (sigma) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        cnt_r <= '0;
        // a null vector has no angle: answer zero at once
        if (vec_i && x_i == '0 && y_i == '0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      vec_r <= vec_i;
      q_r   <= t_rot[31:30];
      if (vec_i) begin
        x_r    <= x_i[COR_XY_W-1] ? -x_i : x_i;
        y_r    <= x_i[COR_XY_W-1] ? -y_i : y_i;
        z_r    <= '0;
        base_r <= x_i[COR_XY_W-1];
        ang_r  <= '0;
      end else begin
        x_r    <= COR_KINV;
        y_r    <= '0;
        z_r    <= $signed({4'b0, t_rot[29:0]}) - 34'sd536870912;
        base_r <= 1'b0;
      end
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      if (last) begin
        ang_r <= {base_r, 31'd0} + z_nxt[31:0];
        case (q_r)
          2'd0: begin
            cos_r <= x_nxt;
            sin_r <= y_nxt;
          end
          2'd1: begin
            cos_r <= -y_nxt;
            sin_r <= x_nxt;
          end
          2'd2: begin
            cos_r <= -x_nxt;
            sin_r <= -y_nxt;
          end
          default: begin
            cos_r <= y_nxt;
            sin_r <= -x_nxt;
          end
        endcase
      end
    end
  end

  assign done_o = done_r;
  assign cos_o  = cos_r;
  assign sin_o  = sin_r;
  assign ang_o  = ang_r;

endmodule

// File: src/asp_div.sv
// ----------------------------------------------------------------------------
// asp_div
// Restoring divider for the mean motion, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asp_div
  import asp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  logic [DIV_D_W-1:0] d_i,
  output logic               done_o,
  output logic [63:0]        q_o
);

  localparam int CW = $clog2(DIV_N_W);

  logic               busy_r;
  logic               done_r;
  logic [CW-1:0]      cnt_r;
  logic [DIV_N_W-1:0] num_r;
  logic [DIV_D_W-1:0] d_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [63:0]        q_r;
  logic               ovf_r;
  logic [63:0]        res_r;

  logic [DIV_D_W:0]   trial;
  logic               ge;
  logic [DIV_D_W:0]   diff;
  logic [63:0]        q_nxt;
  logic               ovf_nxt;

  assign trial   = {rem_r, num_r[DIV_N_W-1]};
  assign ge      = trial >= {1'b0, d_r};
  assign diff    = trial - {1'b0, d_r};
  assign q_nxt   = {q_r[62:0], ge};
  // quotient bits above bit 63 mean saturation
  assign ovf_nxt = ovf_r | q_r[63];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      num_r <= DIV_NUM;
      d_r   <= d_i;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      q_r   <= q_nxt;
      ovf_r <= ovf_nxt;
      if (cnt_r == CW'(DIV_N_W - 1)) begin
        res_r <= ovf_nxt ? '1 : q_nxt;
      end
    end
  end

  assign done_o = done_r;
  assign q_o    = res_r;

endmodule

// File: src/asp_sqrt.sv
// ----------------------------------------------------------------------------
// asp_sqrt
// Bitwise integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module asp_sqrt
  import asp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start_i,
  input  logic [SQ_W-1:0] v_i,
  output logic            done_o,
  output logic [21:0]     r_o
);

  logic            busy_r;
  logic            done_r;
  logic [SQ_W-1:0] v_r, r_r, b_r;
  logic [SQ_W-1:0] rb;
  logic            take;

  assign rb   = r_r + b_r;
  assign take = v_r >= rb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
      end else if (busy_r && b_r == SQ_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      v_r <= v_i;
      r_r <= '0;
      b_r <= SQ_W'(1) << (SQ_W - 1);
    end else if (busy_r) begin
      if (take) begin
        v_r <= v_r - rb;
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

  assign done_o = done_r;
  assign r_o    = r_r[21:0];

endmodule

// File: src/almanac_satellite_position_core.sv
// ----------------------------------------------------------------------------
// almanac_satellite_position_core
// ECEF satellite position from one almanac record and a time of week.
// ----------------------------------------------------------------------------
// One record is worked at a time; in_ch.ready is high only while the core is
// idle, and a finished position waits in an output register so the next
// record can be taken meanwhile. A sequencer drives four shared units: a
// multiplier, a CORDIC, a restoring divider for the mean motion and a square
// root. The Kepler loop makes at most KEPLER_MAX_ITER updates.
// ----------------------------------------------------------------------------
module almanac_satellite_position_core
  import asp_pkg::*;
#(
  parameter int KEPLER_MAX_ITER = 16,
  parameter int CORDIC_STEPS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  asp_in_if.sink      in_ch,
  asp_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(KEPLER_MAX_ITER + 1);

  function automatic logic signed [MUL_P_W-1:0] rsh(input logic signed [MUL_P_W-1:0] x,
                                                    input int unsigned n);
    return (x + (MUL_P_W'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [MUL_P_W-1:0] v);
    logic [31:0] r;
    if (v > MUL_P_W'(64'sd2147483647)) r = 32'h7FFF_FFFF;
    else if (v < -MUL_P_W'(64'sd2147483648)) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  state_t state_r;
  step_t  step_r;

  // captured record
  logic signed [25:0] tk_r;
  logic [19:0]        alm_r;
  logic [31:0]        m0_r, inc_r, om0_r;
  logic [23:0]        s_r;
  logic [20:0]        e_r;
  logic [31:0]        perigee_r;

  // working registers
  logic [47:0]        ss_r;
  logic [71:0]        d3_r;
  logic [63:0]        nq_r;
  logic [31:0]        mk_r, ek_r, old_r, uk_r, omk_r;
  logic [IW-1:0]      it_r;
  logic               conv_r;
  logic signed [35:0] cose_r, sine_r, cu_r, su_r, co_r, so_r, ci_r, si_r;
  logic signed [33:0] t1_r, f_r, xkk_r, ykk_r, yci_r;
  logic [42:0]        v_r;
  logic [21:0]        sq_r;
  logic signed [35:0] yat_r;
  logic [31:0]        r16_r;
  logic [63:0]        pn_r;
  logic signed [65:0] pa_r;
  logic [31:0]        px_r, py_r, pz_r;

  // output register
  logic               out_vld_r;
  logic [31:0]        out_x_r, out_y_r, out_z_r;
  logic               out_conv_r;

  // unit ports
  logic                       mul_start, cor_start, div_start, sq_start;
  logic                       mul_done, cor_done, div_done, sq_done;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic                       cor_vec;
  logic [31:0]                cor_ang;
  logic signed [35:0]         cor_x, cor_y, cor_c, cor_s;
  logic [31:0]                cor_ang_o;
  logic [63:0]                div_q;
  logic [21:0]                sq_r_o;

  logic                       in_fire, unit_done, can_load, close;
  logic signed [25:0]         tk_raw;
  logic [31:0]                kdiff;
  logic signed [MUL_P_W-1:0]  rs20, rs21, rs32, sum_sel, rsum30;
  logic signed [35:0]         f_raw;
  logic [63:0]                mk_acc, node_acc;

  asp_mul u_mul (
    .clk, .rst_n, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  asp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start_i(cor_start), .vec_i(cor_vec), .ang_i(cor_ang),
    .x_i(cor_x), .y_i(cor_y), .done_o(cor_done), .cos_o(cor_c), .sin_o(cor_s),
    .ang_o(cor_ang_o)
  );

  asp_div u_div (
    .clk, .rst_n, .start_i(div_start), .d_i(d3_r), .done_o(div_done), .q_o(div_q)
  );

  asp_sqrt u_sqrt (
    .clk, .rst_n, .start_i(sq_start), .v_i(v_r), .done_o(sq_done), .r_o(sq_r_o)
  );

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign unit_done = mul_done | cor_done | div_done | sq_done;
  assign can_load  = !out_vld_r || out_ch.ready;

  assign tk_raw = $signed({2'b0, in_ch.ref_time}) - $signed({2'b0, in_ch.alm_time, 4'b0});
  assign kdiff  = ek_r - old_r;
  assign close  = (kdiff == 32'd0) || (kdiff == 32'd1) || (kdiff == 32'hFFFF_FFFF);

  assign rs20     = rsh(mul_p, 20);
  assign rs21     = rsh(mul_p, 21);
  assign rs32     = rsh(mul_p, 32);
  assign sum_sel  = (step_r == ST_P2) ? MUL_P_W'(pa_r) - mul_p :
                    (step_r == ST_P4) ? MUL_P_W'(pa_r) + mul_p : mul_p;
  assign rsum30   = rsh(sum_sel, 30);
  assign f_raw    = 36'sd1073741824 - rs21[35:0];
  assign mk_acc   = mul_p[63:0] + 64'h80_0000;
  assign node_acc = 64'd0 - pn_r - mul_p[63:0] + 64'h80_0000;

  // operand selection and unit launch
  always_comb begin
    mul_start = 1'b0;
    cor_start = 1'b0;
    div_start = 1'b0;
    sq_start  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    cor_vec   = 1'b0;
    cor_ang   = ek_r;
    cor_x     = 36'(cose_r - $signed({6'b0, e_r, 9'b0}));
    cor_y     = yat_r;
    case (step_r)
      ST_SS:   begin mul_a = 65'(s_r);          mul_b = 40'(s_r);   end
      ST_S3:   begin mul_a = 65'(ss_r);         mul_b = 40'(s_r);   end
      ST_MK:   begin mul_a = $signed({1'b0, nq_r}); mul_b = 40'(tk_r); end
      ST_KM1:  begin mul_a = 65'(sine_r);       mul_b = 40'(e_r);   end
      ST_KM2:  begin mul_a = 65'(t1_r);         mul_b = INV_PI_Q32; end
      ST_EE:   begin mul_a = 65'(e_r);          mul_b = 40'(e_r);   end
      ST_SQS:  begin mul_a = 65'(sine_r);       mul_b = 40'(sq_r);  end
      ST_ECOS: begin mul_a = 65'(cose_r);       mul_b = 40'(e_r);   end
      ST_R16:  begin mul_a = 65'(ss_r[47:16]);  mul_b = 40'(f_r);   end
      ST_XK:   begin mul_a = 65'(cu_r);         mul_b = 40'(r16_r); end
      ST_YK:   begin mul_a = 65'(su_r);         mul_b = 40'(r16_r); end
      ST_N1:   begin mul_a = NODE_TK_NEG;       mul_b = 40'(tk_r);  end
      ST_N2:   begin mul_a = NODE_AL_NEG;       mul_b = 40'(alm_r); end
      ST_YCI:  begin mul_a = 65'(ci_r);         mul_b = 40'(ykk_r); end
      ST_P1:   begin mul_a = 65'(co_r);         mul_b = 40'(xkk_r); end
      ST_P2:   begin mul_a = 65'(so_r);         mul_b = 40'(yci_r); end
      ST_P3:   begin mul_a = 65'(so_r);         mul_b = 40'(xkk_r); end
      ST_P4:   begin mul_a = 65'(co_r);         mul_b = 40'(yci_r); end
      ST_P5:   begin mul_a = 65'(si_r);         mul_b = 40'(ykk_r); end
      ST_ATAN: cor_vec = 1'b1;
      ST_UCOR: cor_ang = uk_r;
      ST_OCOR: cor_ang = omk_r;
      ST_ICOR: cor_ang = inc_r;
      default: ;
    endcase
    if (state_r == S_ISSUE) begin
      case (step_r)
        ST_KCHK: ;
        ST_DIV:  div_start = 1'b1;
        ST_SQRT: sq_start  = 1'b1;
        ST_KCOR, ST_ECOR, ST_ATAN, ST_UCOR, ST_OCOR, ST_ICOR: cor_start = 1'b1;
        default: mul_start = 1'b1;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= ST_SS;
      out_vld_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && can_load) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_ISSUE;
            step_r  <= ST_SS;
          end
        end
        S_ISSUE: begin
          if (step_r == ST_KCHK) begin
            step_r <= (it_r < IW'(KEPLER_MAX_ITER) && !close) ? ST_KCOR : ST_ECOR;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (unit_done) begin
            if (step_r == ST_P5) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_ISSUE;
              step_r  <= (step_r == ST_KM2) ? ST_KCHK : step_t'(step_r + 5'd1);
            end
          end
        end
        S_FIN: begin
          if (can_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perigee_r <= PERIGEE_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_PERIGEE_IDX) begin
      perigee_r <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PERIGEE_IDX) ? perigee_r : 32'd0;

  // datapath write-back
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (tk_raw > HALF_WEEK16) tk_r <= tk_raw - WEEK16;
      else if (tk_raw < -HALF_WEEK16) tk_r <= tk_raw + WEEK16;
      else tk_r <= tk_raw;
      alm_r <= in_ch.alm_time;
      m0_r  <= in_ch.mean_anom0;
      s_r   <= in_ch.sqrt_axis;
      e_r   <= in_ch.eccentricity;
      inc_r <= in_ch.inclination;
      om0_r <= in_ch.node_long0;
    end
    if (state_r == S_ISSUE && step_r == ST_KCHK) begin
      if (it_r < IW'(KEPLER_MAX_ITER) && !close) old_r <= ek_r;
      else conv_r <= close;
    end
    if (state_r == S_WAIT && unit_done) begin
      case (step_r)
        ST_SS:  ss_r <= mul_p[47:0];
        ST_S3:  d3_r <= mul_p[71:0];
        ST_DIV: nq_r <= div_q;
        ST_MK: begin
          mk_r  <= m0_r + mk_acc[55:24];
          ek_r  <= m0_r + mk_acc[55:24];
          old_r <= '0;
          it_r  <= '0;
        end
        ST_KCOR, ST_ECOR: begin
          cose_r <= cor_c;
          sine_r <= cor_s;
        end
        ST_KM1: t1_r <= rs20[33:0];
        ST_KM2: begin
          ek_r <= mk_r + rs32[31:0];
          it_r <= it_r + 1'b1;
        end
        ST_EE:   v_r   <= 43'h400_0000_0000 - mul_p[42:0];
        ST_SQRT: sq_r  <= sq_r_o;
        ST_SQS:  yat_r <= rs21[35:0];
        ST_ATAN: uk_r  <= cor_ang_o + perigee_r;
        ST_ECOS: f_r   <= f_raw[35] ? 34'sd0 : f_raw[33:0];
        ST_R16:  r16_r <= mul_p[63:32];
        ST_UCOR: begin
          cu_r <= cor_c;
          su_r <= cor_s;
        end
        ST_XK: xkk_r <= rsum30[33:0];
        ST_YK: ykk_r <= rsum30[33:0];
        ST_N1: pn_r  <= mul_p[63:0];
        ST_N2: omk_r <= om0_r + node_acc[55:24];
        ST_OCOR: begin
          co_r <= cor_c;
          so_r <= cor_s;
        end
        ST_ICOR: begin
          ci_r <= cor_c;
          si_r <= cor_s;
        end
        ST_YCI: yci_r <= rsum30[33:0];
        ST_P1, ST_P3: pa_r <= mul_p[65:0];
        ST_P2: px_r <= sat32(rsum30);
        ST_P4: py_r <= sat32(rsum30);
        ST_P5: pz_r <= sat32(rsum30);
        default: ;
      endcase
    end
    if (state_r == S_FIN && can_load) begin
      out_x_r    <= px_r;
      out_y_r    <= py_r;
      out_z_r    <= pz_r;
      out_conv_r <= conv_r;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.pos_x     = out_x_r;
  assign out_ch.pos_y     = out_y_r;
  assign out_ch.pos_z     = out_z_r;
  assign out_ch.converged = out_conv_r;

`ifndef SYNTHESIS
  // a taken record closes the input until the position is finished
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input still open after a transaction");

  // the shared units never finish together
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mul_done, cor_done, div_done, sq_done}))
    else $error("two arithmetic units finished in the same cycle");

  // a unit only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    unit_done |-> state_r == S_WAIT)
    else $error("unit result outside the wait state");

  // a new result is only loaded from the finish state
  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_FIN))
    else $error("result valid without a finished computation");
`endif

endmodule

// File: tb/asp_position_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// asp_position_checker
// Watches the record and position channels and the register port, predicts
// the ECEF position of every accepted record and compares it with the
// positions that leave the core, oldest first.
// ----------------------------------------------------------------------------
module asp_position_checker (
  input  logic        clk,
  input  logic        rst_n,
  asp_in_if           rec_mon,
  asp_out_if          pos_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  import asp_pkg::*;

  localparam int KEPLER_ITER = 16;
  localparam int ROT_STEPS   = 32;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               conv;
  } position_t;

  localparam longint ATAN_STEP [0:31] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000
  };

  logic [31:0] perigee;
  position_t   expected_pos [$];

  // round half up, then arithmetic shift
  function automatic longint round_shift(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic void sin_cos(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] t;
    longint      x, y, z, dx, dy;
    t = ang + 32'h20000000;
    z = longint'(t[29:0]) - 64'sh20000000;
    x = 652032874;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
      end
    end
    case (t[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [31:0] vector_angle(input longint y0, input longint x0);
    logic [31:0] base;
    longint      x, y, z, dx, dy;
    base = 32'h0;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) return 32'h0;
    if (x < 0) begin
      x = -x; y = -y; base = 32'h80000000;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
      end else begin
        x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
      end
    end
    return base + z[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v0);
    longint unsigned v, r, b;
    v = v0;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] motion_rate(input logic [23:0] s);
    logic [107:0] num, den, q;
    if (s == 0) return '1;
    num = {64'd6987452575800000000, 44'd0};
    den = 108'(s) * 108'(s) * 108'(s);
    q   = num / den;
    if (q[107:64] != 0) return '1;
    return q[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic position_t predict_position(
    input logic [23:0] ref_time, input logic [19:0] alm_time,
    input logic [31:0] m0, input logic [23:0] sqa, input logic [20:0] ecc,
    input logic [31:0] incl, input logic [31:0] node0, input logic [31:0] arg_per);
    position_t       p;
    longint          tk, e, sin_e, cos_e, sq, f, cu, su, ci, si, co, so, xk, yk, yci, term;
    longint unsigned nq, r16, acc, prod;
    logic [31:0]     mk, ek, prev, uk, omk, dif;
    int              it;
    tk = longint'(ref_time) - 16 * longint'(alm_time);
    if (tk > 4838400) tk = tk - 9676800;
    else if (tk < -4838400) tk = tk + 9676800;
    nq   = motion_rate(sqa);
    prod = (nq * longint'(unsigned'(tk)) + 64'h800000) >> 24;
    mk   = m0 + prod[31:0];
    e    = longint'(ecc);
    prev = 32'h0;
    ek   = mk;
    it   = 0;
    dif  = ek - prev;
    while (it < KEPLER_ITER && ($signed(dif) > 1 || $signed(dif) < -1)) begin
      prev = ek;
      sin_cos(ek, cos_e, sin_e);
      term = round_shift(round_shift(e * sin_e, 20) * 64'sd1367130551, 32);
      ek   = mk + term[31:0];
      it++;
      dif  = ek - prev;
    end
    p.conv = ($signed(dif) <= 1 && $signed(dif) >= -1);
    sin_cos(ek, cos_e, sin_e);
    sq = longint'(int_sqrt((64'd1 << 42) - 64'(e * e)));
    uk = vector_angle(round_shift(sq * sin_e, 21), cos_e - (e <<< 9)) + arg_per;
    f  = (64'sd1 << 30) - round_shift(e * cos_e, 21);
    if (f < 0) f = 0;
    r16 = (((64'(sqa) * 64'(sqa)) >> 16) * 64'(f)) >> 32;
    sin_cos(uk, cu, su);
    xk  = round_shift(longint'(r16) * cu, 30);
    yk  = round_shift(longint'(r16) * su, 30);
    acc = 64'd0 - 64'(tk) * 64'd52273558800 - 64'(alm_time) * 64'd836283265931;
    prod = (acc + 64'h800000) >> 24;
    omk = node0 + prod[31:0];
    sin_cos(omk, co, so);
    sin_cos(incl, ci, si);
    yci = round_shift(yk * ci, 30);
    p.x = clamp32(round_shift(xk * co - yci * so, 30));
    p.y = clamp32(round_shift(xk * so + yci * co, 30));
    p.z = clamp32(round_shift(yk * si, 30));
    return p;
  endfunction

  always_comb pending = expected_pos.size();

  always @(posedge clk) begin
    position_t want;
    if (!rst_n) begin
      perigee <= PERIGEE_RST;
      expected_pos.delete();
      errors  <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0) perigee <= pwdata;
      if (rec_mon.valid && rec_mon.ready)
        expected_pos.push_back(predict_position(rec_mon.ref_time, rec_mon.alm_time,
          rec_mon.mean_anom0, rec_mon.sqrt_axis, rec_mon.eccentricity,
          rec_mon.inclination, rec_mon.node_long0, perigee));
      if (pos_mon.valid && pos_mon.ready) begin
        if (expected_pos.size() == 0) begin
          $error("position transaction with no record outstanding");
          errors <= errors + 1;
        end else begin
          want = expected_pos.pop_front();
          if (want.x !== pos_mon.pos_x || want.y !== pos_mon.pos_y ||
              want.z !== pos_mon.pos_z || want.conv !== pos_mon.converged)
            errors <= errors + 1;
          if (want.x !== pos_mon.pos_x)
            $error("pos_x expected %0d actual %0d", want.x, pos_mon.pos_x);
          if (want.y !== pos_mon.pos_y)
            $error("pos_y expected %0d actual %0d", want.y, pos_mon.pos_y);
          if (want.z !== pos_mon.pos_z)
            $error("pos_z expected %0d actual %0d", want.z, pos_mon.pos_z);
          if (want.conv !== pos_mon.converged)
            $error("converged expected %0b actual %0b", want.conv, pos_mon.converged);
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives almanac records and perigee settings into the satellite position
// core with random gaps and output stalls; the checker judges every position.
// ----------------------------------------------------------------------------
module tb_top;
  import asp_pkg::*;

  localparam int          WATCHDOG_LIMIT = 20000;
  localparam logic [23:0] NOMINAL_AXIS   = 24'd10554000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  int          records_sent = 0;
  bit          calm = 1'b0;
  int          idle_cycles = 0;

  asp_in_if  rec_ch ();
  asp_out_if pos_ch ();

  always #6 clk = ~clk;

  almanac_satellite_position_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (rec_ch),
    .out_ch  (pos_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  asp_position_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .rec_mon (rec_ch),
    .pos_mon (pos_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    rec_ch.valid        = 1'b0;
    rec_ch.ref_time     = '0;
    rec_ch.alm_time     = '0;
    rec_ch.mean_anom0   = '0;
    rec_ch.sqrt_axis    = '0;
    rec_ch.eccentricity = '0;
    rec_ch.inclination  = '0;
    rec_ch.node_long0   = '0;
    pos_ch.ready        = 1'b0;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((rec_ch.valid && rec_ch.ready) || (pos_ch.valid && pos_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // position receiver: random stall bursts, one long hold-off to back up the core
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && records_sent >= 300) begin
        held = 1'b1;
        pos_ch.ready <= 1'b0;
        repeat (5000) @(negedge clk);
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        pos_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      pos_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  task automatic write_perigee(input logic [31:0] value);
    // no record may be offered or in flight around a register write
    rec_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 3'd0;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_record(input logic [23:0] rt, input logic [19:0] alm,
                             input logic [31:0] m0, input logic [23:0] sqa,
                             input logic [20:0] ecc, input logic [31:0] incl,
                             input logic [31:0] node0);
    if (!calm && $urandom_range(0, 4) == 0) begin
      rec_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    rec_ch.valid        <= 1'b1;
    rec_ch.ref_time     <= rt;
    rec_ch.alm_time     <= alm;
    rec_ch.mean_anom0   <= m0;
    rec_ch.sqrt_axis    <= sqa;
    rec_ch.eccentricity <= ecc;
    rec_ch.inclination  <= incl;
    rec_ch.node_long0   <= node0;
    do @(posedge clk); while (!rec_ch.ready);
    records_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    logic [23:0] rt, sqa;
    logic [19:0] alm;
    logic [20:0] ecc;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        // plausible orbit, random geometry
        alm = 20'($urandom_range(0, 604799));
        rt  = 24'($urandom_range(0, 9676799));
        sqa = NOMINAL_AXIS + 24'($urandom_range(0, 131071)) - 24'd65536;
        ecc = ($urandom_range(0, 3) == 0) ? 21'($urandom_range(0, 524287)) :
                                            21'($urandom_range(0, 32767));
      end else begin
        alm = 20'($urandom);
        rt  = 24'($urandom);
        sqa = ($urandom_range(0, 7) == 0) ? 24'd0 : 24'($urandom);
        ecc = 21'($urandom);
      end
      send_record(rt, alm, $urandom, sqa, ecc, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed records at the reset perigee
    send_record(24'd1600000, 20'd90000, 32'd0, NOMINAL_AXIS, 21'd10000, 32'd644245094, 32'd0);
    send_record('0, '0, '0, '0, '0, '0, '0);
    send_record('1, '1, 32'h7FFFFFFF, '1, '1, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_record(24'd123456, 20'd7, 32'h80000000, NOMINAL_AXIS, 21'd4000,
                32'h80000000, 32'h80000000);
    send_record(24'd9676799, 20'd0, 32'h12345678, NOMINAL_AXIS, 21'd20000, 32'd644245094, '0);
    send_record(24'd0, 20'd604799, 32'h9ABCDEF0, NOMINAL_AXIS, 21'd20000, 32'd644245094, '0);
    send_record(24'd4838400, 20'd0, 32'h40000000, NOMINAL_AXIS, 21'd8000, 32'd644245094, '1);
    send_record(24'd0, 20'd302400, 32'hC0000000, NOMINAL_AXIS, 21'd8000, 32'd644245094, '1);
    send_record(24'hFFFFFF, 20'd0, 32'h01000000, NOMINAL_AXIS, 21'd8000, 32'd644245094, '0);
    send_record(24'd0, 20'hFFFFF, 32'h01000000, NOMINAL_AXIS, 21'd8000, 32'd644245094, '0);
    send_record(24'd5000000, 20'd1000, 32'h11111111, 24'd0, 21'd30000, 32'd644245094, '0);
    // high eccentricity, iteration may run out
    send_record(24'd5000000, 20'd1000, 32'h30000000, NOMINAL_AXIS, 21'h1FFFFF, 32'd1, '0);
    // zero anomaly with extreme eccentricity, atan2 arguments near null
    send_record(24'd160000, 20'd10000, 32'd0, NOMINAL_AXIS, 21'h1FFFFF, 32'd644245094, '0);
    send_record(24'd160000, 20'd10000, 32'd0, NOMINAL_AXIS, 21'd0, 32'd0, '0);
    // radius beyond the coordinate range
    send_record(24'd400000, 20'd20000, 32'h20000000, 24'hFFFFFF, 21'd0, 32'h20000000, 32'h0);
    send_record(24'd400000, 20'd20000, 32'h20000000, 24'd1, 21'd100, 32'h20000000, 32'h0);

    write_perigee(32'h80000000);
    send_random(250);
    write_perigee(32'h7FFFFFFF);
    send_random(250);
    write_perigee($urandom);
    send_random(150);
    calm = 1'b1;
    send_random(100);
    rec_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (2000) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
src/asp_pkg.sv
src/asp_if.sv
src/asp_mul.sv
src/asp_cordic.sv
src/asp_div.sv
src/asp_sqrt.sv
src/almanac_satellite_position_core.sv
tb/asp_position_checker.sv
tb/tb_top.sv
